@@ hdl/fsip_pkg.sv @@
// Shared types and constants for the integer format printer.
package fsip_pkg;

	localparam int MAX_PAD_DEF = 40;
	localparam int Q_DEPTH_DEF = 4;
	localparam int PAD_W       = 6;
	localparam int LEN_W       = 16;
	localparam int ARG_W       = 64;
	localparam int NDIG        = 22;
	localparam int NBCD        = 20;
	localparam int DIG_W       = 4 * NDIG;
	localparam int REM_W       = 5;
	localparam int BIT_W       = 7;

	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_A_OFS = 8'h57;
	localparam logic [7:0] CH_C     = 8'h63;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_L     = 8'h6c;
	localparam logic [7:0] CH_O     = 8'h6f;
	localparam logic [7:0] CH_X     = 8'h78;

	typedef enum logic [1:0] {
		K_CHAR = 2'd0,
		K_NUM  = 2'd1,
		K_END  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		B_DEC = 2'd0,
		B_HEX = 2'd1,
		B_OCT = 2'd2
	} base_t;

	typedef struct packed {
		kind_t              kind;
		logic [7:0]         ch;
		logic               status;
		logic [PAD_W-1:0]   pad;
		logic               neg;
		base_t              base;
		logic [ARG_W-1:0]   mag;
	} cmd_t;

endpackage

@@ hdl/fsip_front.sv @@
// Front end: parses format characters and issues output commands.
module fsip_front #(
	parameter int MAX_PAD = fsip_pkg::MAX_PAD_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [7:0]        fmt_char,
	input  logic [63:0]       arg_value,
	input  logic              end_of_format,
	output logic              push,
	output fsip_pkg::cmd_t    cmd
);

	localparam logic [fsip_pkg::PAD_W-1:0] PAD_MAX = fsip_pkg::PAD_W'(MAX_PAD);

	logic                       in_spec_q;
	logic                       halted_q;
	logic [fsip_pkg::PAD_W-1:0] pad_q;
	logic [1:0]                 long_q;

	logic        wide;
	logic [63:0] sval;
	logic        sneg;
	logic [63:0] smag;

	assign wide = (long_q != 2'd0);
	assign sval = wide ? arg_value : {{32{arg_value[31]}}, arg_value[31:0]};
	assign sneg = sval[63];
	assign smag = sneg ? (64'd0 - sval) : sval;

	always_comb begin
		push     = 1'b0;
		cmd      = '0;
		cmd.kind = fsip_pkg::K_CHAR;
		cmd.base = fsip_pkg::B_DEC;
		if (fire) begin
			if (end_of_format) begin
				push       = 1'b1;
				cmd.kind   = fsip_pkg::K_END;
				cmd.status = halted_q | in_spec_q;
			end else if (!halted_q) begin
				if (!in_spec_q) begin
					if (fmt_char != fsip_pkg::CH_PCT) begin
						push   = 1'b1;
						cmd.ch = fmt_char;
					end
				end else begin
					priority case (fmt_char)
						fsip_pkg::CH_C: begin
							push   = 1'b1;
							cmd.ch = arg_value[7:0];
						end
						fsip_pkg::CH_PCT: begin
							push   = 1'b1;
							cmd.ch = fsip_pkg::CH_PCT;
						end
						fsip_pkg::CH_D, fsip_pkg::CH_I: begin
							push     = (long_q != 2'd3);
							cmd.kind = fsip_pkg::K_NUM;
							cmd.base = fsip_pkg::B_DEC;
							cmd.neg  = sneg;
							cmd.mag  = smag;
							cmd.pad  = (fmt_char == fsip_pkg::CH_D) ? pad_q : '0;
						end
						fsip_pkg::CH_X: begin
							push     = (long_q != 2'd3);
							cmd.kind = fsip_pkg::K_NUM;
							cmd.base = fsip_pkg::B_HEX;
							cmd.mag  = wide ? arg_value : {32'd0, arg_value[31:0]};
						end
						fsip_pkg::CH_O: begin
							push     = (long_q != 2'd3);
							cmd.kind = fsip_pkg::K_NUM;
							cmd.base = fsip_pkg::B_OCT;
							cmd.mag  = wide ? arg_value : {32'd0, arg_value[31:0]};
						end
						default: begin
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_spec_q <= 1'b0;
			halted_q  <= 1'b0;
			pad_q     <= '0;
			long_q    <= 2'd0;
		end else if (fire) begin
			if (end_of_format) begin
				in_spec_q <= 1'b0;
				halted_q  <= 1'b0;
				pad_q     <= '0;
				long_q    <= 2'd0;
			end else if (!halted_q) begin
				if (!in_spec_q) begin
					if (fmt_char == fsip_pkg::CH_PCT) begin
						in_spec_q <= 1'b1;
						pad_q     <= '0;
						long_q    <= 2'd0;
					end
				end else begin
					priority case (fmt_char)
						fsip_pkg::CH_C, fsip_pkg::CH_PCT: in_spec_q <= 1'b0;
						fsip_pkg::CH_SPACE: begin
							if (pad_q < PAD_MAX)
								pad_q <= pad_q + 1'b1;
						end
						fsip_pkg::CH_L: begin
							if (long_q != 2'd3)
								long_q <= long_q + 2'd1;
						end
						fsip_pkg::CH_D, fsip_pkg::CH_I, fsip_pkg::CH_X, fsip_pkg::CH_O: begin
							in_spec_q <= 1'b0;
							if (long_q == 2'd3)
								halted_q <= 1'b1;
						end
						default: begin
							in_spec_q <= 1'b0;
							halted_q  <= 1'b1;
						end
					endcase
				end
			end
		end
	end

endmodule

@@ hdl/fsip_queue.sv @@
// Command queue between front end and back end.
module fsip_queue #(
	parameter int DEPTH = fsip_pkg::Q_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  fsip_pkg::cmd_t wr_cmd,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output fsip_pkg::cmd_t rd_cmd
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	fsip_pkg::cmd_t mem_q [DEPTH];
	logic [AW-1:0]  wp_q;
	logic [AW-1:0]  rp_q;
	logic [AW:0]    cnt_q;

	assign full      = (cnt_q == (AW+1)'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign rd_cmd    = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (pop)
				rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!not_empty |-> !pop) else $error("pop from empty queue");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count lost a push");
`endif

endmodule

@@ hdl/fsip_back.sv @@
// Back end: expands commands into output bytes and closing results.
module fsip_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  fsip_pkg::cmd_t cmd,
	output logic           cmd_pop,
	input  logic [15:0]    buffer_limit,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [47:0]    m_tdata,
	output logic           m_tlast,
	output logic [0:0]     m_tuser
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DAB  = 5'b00010,
		ST_PAD  = 5'b00100,
		ST_SIGN = 5'b01000,
		ST_DIG  = 5'b10000
	} state_t;

	state_t                        state_q;
	logic [15:0]                   len_q;
	logic [fsip_pkg::PAD_W-1:0]    pad_q;
	logic                          neg_q;
	logic [63:0]                   shift_q;
	logic [fsip_pkg::BIT_W-1:0]    bit_q;
	logic [fsip_pkg::DIG_W-1:0]    dig_q;
	logic [fsip_pkg::REM_W-1:0]    rem_q;
	logic                          started_q;

	logic        ov_q, ost_q, olast_q, odone_q, ostat_q;
	logic [7:0]  oc_q;
	logic [15:0] opos_q, otot_q;

	logic        slot, emit, elast, fin, skip;
	logic [7:0]  ech;
	logic [3:0]  dtop;
	logic        st_byte, ch_ok;
	logic [15:0] len_inc;
	logic [fsip_pkg::DIG_W-1:0] adj;
	logic [fsip_pkg::DIG_W-1:0] oct_lay;
	logic [65:0] mag_ext;

	assign slot    = !ov_q || m_tready;
	assign dtop    = dig_q[fsip_pkg::DIG_W-1 -: 4];
	assign skip    = !started_q && (dtop == 4'd0) && (rem_q != 5'd1);
	assign st_byte = (len_q < buffer_limit);
	assign ch_ok   = ({1'b0, len_q} + 17'd1) < {1'b0, buffer_limit};
	assign len_inc = (len_q == 16'hffff) ? len_q : len_q + 16'd1;
	assign mag_ext = {2'b00, cmd.mag};

	always_comb begin
		adj = '0;
		for (int j = 0; j < fsip_pkg::NBCD; j++)
			adj[4*j +: 4] = (dig_q[4*j +: 4] >= 4'd5) ? dig_q[4*j +: 4] + 4'd3 : dig_q[4*j +: 4];
	end

	always_comb begin
		oct_lay = '0;
		for (int k = 0; k < fsip_pkg::NDIG; k++)
			oct_lay[4*k +: 4] = {1'b0, mag_ext[3*k +: 3]};
	end

	always_comb begin
		emit    = 1'b0;
		ech     = '0;
		elast   = 1'b0;
		fin     = 1'b0;
		cmd_pop = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.kind)
						fsip_pkg::K_CHAR: begin
							if (slot) begin
								emit    = 1'b1;
								ech     = cmd.ch;
								elast   = 1'b1;
								cmd_pop = 1'b1;
							end
						end
						fsip_pkg::K_END: begin
							if (slot) begin
								fin     = 1'b1;
								cmd_pop = 1'b1;
							end
						end
						fsip_pkg::K_NUM: cmd_pop = 1'b1;
						default: begin
						end
					endcase
				end
			end
			ST_DAB: begin
			end
			ST_PAD: begin
				if (pad_q != '0 && slot) begin
					emit = 1'b1;
					ech  = fsip_pkg::CH_SPACE;
				end
			end
			ST_SIGN: begin
				if (slot) begin
					emit = 1'b1;
					ech  = fsip_pkg::CH_MINUS;
				end
			end
			ST_DIG: begin
				if (!skip && slot) begin
					emit  = 1'b1;
					ech   = (dtop < 4'd10) ? fsip_pkg::CH_ZERO + {4'b0, dtop}
					                       : fsip_pkg::CH_A_OFS + {4'b0, dtop};
					elast = (rem_q == 5'd1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_pop && cmd.kind == fsip_pkg::K_NUM) begin
					pad_q     <= cmd.pad;
					neg_q     <= cmd.neg;
					shift_q   <= cmd.mag;
					bit_q     <= 7'd64;
					rem_q     <= 5'(fsip_pkg::NDIG);
					started_q <= 1'b0;
					unique case (cmd.base)
						fsip_pkg::B_HEX: dig_q <= {24'd0, cmd.mag};
						fsip_pkg::B_OCT: dig_q <= oct_lay;
						default:         dig_q <= '0;
					endcase
				end
			end
			ST_DAB: begin
				dig_q   <= {8'd0, adj[78:0], shift_q[63]};
				shift_q <= {shift_q[62:0], 1'b0};
				bit_q   <= bit_q - 7'd1;
			end
			ST_PAD: begin
				if (emit)
					pad_q <= pad_q - 1'b1;
			end
			ST_SIGN: begin
			end
			ST_DIG: begin
				if (skip || emit) begin
					dig_q <= {dig_q[fsip_pkg::DIG_W-5:0], 4'd0};
					rem_q <= rem_q - 5'd1;
				end
				if (emit)
					started_q <= 1'b1;
			end
			default: begin
			end
		endcase
		if (emit) begin
			oc_q    <= (st_byte && ch_ok) ? ech : 8'd0;
			opos_q  <= len_q;
			ost_q   <= st_byte;
			olast_q <= elast;
			odone_q <= 1'b0;
			ostat_q <= 1'b0;
			otot_q  <= '0;
		end else if (fin) begin
			oc_q    <= 8'd0;
			opos_q  <= len_q;
			ost_q   <= st_byte;
			olast_q <= 1'b1;
			odone_q <= 1'b1;
			ostat_q <= cmd.status;
			otot_q  <= len_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (emit) begin
				ov_q  <= 1'b1;
				len_q <= len_inc;
			end else if (fin) begin
				ov_q  <= 1'b1;
				len_q <= '0;
			end else if (m_tready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_pop && cmd.kind == fsip_pkg::K_NUM)
						state_q <= (cmd.base == fsip_pkg::B_DEC) ? ST_DAB : ST_PAD;
				end
				ST_DAB: begin
					if (bit_q == 7'd1)
						state_q <= ST_PAD;
				end
				ST_PAD: begin
					if (pad_q == '0)
						state_q <= neg_q ? ST_SIGN : ST_DIG;
				end
				ST_SIGN: begin
					if (emit)
						state_q <= ST_DIG;
				end
				ST_DIG: begin
					if (emit && rem_q == 5'd1)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = {6'd0, otot_q, ostat_q, ost_q, opos_q, oc_q};
	assign m_tlast  = olast_q;
	assign m_tuser  = odone_q;

`ifndef NO_ASSERTIONS
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && odone_q) |-> olast_q) else $error("closing result without last");
	a_unstored_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !ost_q) |-> oc_q == 8'd0) else $error("unstored byte not zero");
	a_dig_remaining: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIG |-> rem_q != '0) else $error("digit phase with no digits");
`endif

endmodule

@@ hdl/format_string_integer_printer.sv @@
// Top level of the streaming integer format printer.
// Usage:
//  s_* channel: one format character per transaction. s_tdata holds fmt_char
//  and arg_value; s_tlast set closes the format string (fmt_char ignored).
//  m_* channel: one transaction per output byte, then one closing transaction
//  (m_tuser = 1) carrying status and total length. m_tlast marks the last
//  result caused by an input transaction.
//  cfg_* channel: writes buffer_limit; always ready, use only while idle.
// Throughput and sequencing:
//  Front end takes one character per cycle while the command queue has room.
//  Literals, %c and %% emit one byte a cycle while m_tready is high. Decimal
//  goes through the pop, a binary-to-BCD pass over all 64 bits, the pad spaces,
//  the sign if negative and 22 digit slots (leading zeros skip one per cycle).
//  Hex and octal go through the pop, one pass through the pad stage and 22
//  digit slots. The shift-add BCD loop in the back end sets the worst case.
// Reset: all parse state and the output length clear; buffer_limit = 65535.
// Stall: m_tready low holds the output register; the back end waits, the
//  queue fills and then s_tready drops.
module format_string_integer_printer #(
	parameter int MAX_PAD = fsip_pkg::MAX_PAD_DEF,
	parameter int Q_DEPTH = fsip_pkg::Q_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // fmt_char[7:0], arg_value[71:8]
	input  logic        s_tlast,   // end_of_format
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // out_char[7:0], position[23:8], store[24],
	                               // status[25], total_length[41:26], zero[47:42]
	output logic        m_tlast,   // last
	output logic [0:0]  m_tuser,   // done_res
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data   // buffer_limit
);

	logic           fire;
	logic           push;
	logic           q_full;
	logic           q_ne;
	logic           pop;
	fsip_pkg::cmd_t f_cmd;
	fsip_pkg::cmd_t b_cmd;
	logic [15:0]    limit_q;

	assign s_tready  = !q_full;
	assign fire      = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// buffer size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			limit_q <= 16'hffff;
		else if (cfg_valid)
			limit_q <= cfg_data;
	end

	fsip_front #(.MAX_PAD(MAX_PAD)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.fmt_char      (s_tdata[7:0]),
		.arg_value     (s_tdata[71:8]),
		.end_of_format (s_tlast),
		.push          (push),
		.cmd           (f_cmd)
	);

	fsip_queue #(.DEPTH(Q_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_cmd    (f_cmd),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_ne),
		.rd_cmd    (b_cmd)
	);

	fsip_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (q_ne),
		.cmd          (b_cmd),
		.cmd_pop      (pop),
		.buffer_limit (limit_q),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast),
		.m_tuser      (m_tuser)
	);

endmodule

@@ sim/tb.sv @@
// Testbench for the streaming integer format printer: directed table plus random format strings.
`timescale 1ns / 100ps

module tb;

	// Result fields as they come out of m_tdata/m_tlast/m_tuser.
	typedef struct packed {
		logic [7:0]  out_char;
		logic [15:0] position;
		logic        store;
		logic        last;
		logic        done_res;
		logic        status;
		logic [15:0] total_length;
	} byte_res_t;

	// One directed row; chk set means the typed-in first result is compared too.
	typedef struct {
		logic [7:0]  ch;
		logic [63:0] arg;
		logic        eof;
		logic        chk;
		byte_res_t   want;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic        m_tlast;
	logic [0:0]  m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	format_string_integer_printer uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// Printer state mirror
	logic [15:0] limit_q;
	logic        in_spec_q;
	logic [5:0]  pad_q;
	logic [1:0]  longs_q;
	logic [15:0] len_q;
	logic        halt_q;

	byte_res_t   expected_bytes[$];
	byte_res_t   staged[$];
	int          errors;
	int          n_sent;
	int          src_idle_pct;
	int          snk_stall_pct;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit: generous against ~420 items x 60 results x long stalls.
	initial begin
		#200ms;
		$display("Test completed with failures");
		$finish;
	end

	task automatic report(input string what, input byte_res_t got, input byte_res_t want);
		errors++;
		$display("MISMATCH %s: got %h want %h", what, got, want);
	endtask

	function automatic void put_byte(input logic [7:0] c);
		byte_res_t r;
		r = '0;
		r.store    = len_q < limit_q;
		r.out_char = (r.store && (17'(len_q) + 17'd1 < 17'(limit_q))) ? c : 8'h00;
		r.position = len_q;
		staged.push_back(r);
		if (len_q != 16'hffff) len_q++;
	endfunction

	function automatic void put_number(input logic [63:0] v, input int radix);
		logic [7:0] dig[24];
		int         n;
		int         d;
		n = 0;
		do begin
			d = int'(v % radix);
			dig[n] = (d < 10) ? fsip_pkg::CH_ZERO + 8'(d) : fsip_pkg::CH_A_OFS + 8'(d);
			n++;
			v = v / radix;
		end while (v != 0);
		while (n > 0) begin
			n--;
			put_byte(dig[n]);
		end
	endfunction

	// Works out every result caused by one format transaction.
	function automatic void predict_format_char(input logic [7:0] ch, input logic [63:0] arg,
			input logic eof);
		byte_res_t   r;
		logic [63:0] v;
		logic        wide;
		staged.delete();
		if (eof) begin
			r = '0;
			r.position     = len_q;
			r.store        = len_q < limit_q;
			r.done_res     = 1'b1;
			r.status       = halt_q | in_spec_q;
			r.total_length = len_q;
			staged.push_back(r);
			{in_spec_q, pad_q, longs_q, len_q, halt_q} = '0;
		end else if (!halt_q) begin
			if (!in_spec_q) begin
				if (ch == fsip_pkg::CH_PCT) begin
					in_spec_q = 1'b1;
					pad_q     = '0;
					longs_q   = '0;
				end else put_byte(ch);
			end else begin
				wide = longs_q != 0;
				case (ch)
				fsip_pkg::CH_C: begin
					put_byte(arg[7:0]);
					in_spec_q = 1'b0;
				end
				fsip_pkg::CH_PCT: begin
					put_byte(fsip_pkg::CH_PCT);
					in_spec_q = 1'b0;
				end
				fsip_pkg::CH_SPACE: if (pad_q < fsip_pkg::MAX_PAD_DEF) pad_q++;
				fsip_pkg::CH_L: if (longs_q < 3) longs_q++;
				fsip_pkg::CH_D, fsip_pkg::CH_I, fsip_pkg::CH_X, fsip_pkg::CH_O: begin
					in_spec_q = 1'b0;
					if (longs_q > 2) halt_q = 1'b1;
					else if (ch == fsip_pkg::CH_D || ch == fsip_pkg::CH_I) begin
						if (ch == fsip_pkg::CH_D)
							for (int p = 0; p < pad_q; p++) put_byte(fsip_pkg::CH_SPACE);
						v = wide ? arg : {{32{arg[31]}}, arg[31:0]};
						if (v[63]) begin
							put_byte(fsip_pkg::CH_MINUS);
							v = -v;
						end
						put_number(v, 10);
					end else begin
						v = wide ? arg : {32'h0, arg[31:0]};
						put_number(v, ch == fsip_pkg::CH_X ? 16 : 8);
					end
				end
				default: begin
					in_spec_q = 1'b0;
					halt_q    = 1'b1;
				end
				endcase
			end
		end
		if (staged.size() > 0) staged[staged.size()-1].last = 1'b1;
	endfunction

	// Sink side: random stall, compare at the rising edge.
	always @(negedge clk) begin
		if (arst_n) m_tready <= ($urandom_range(99) >= snk_stall_pct);
	end

	always @(posedge clk) begin
		byte_res_t got;
		byte_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[7:0], m_tdata[23:8], m_tdata[24], m_tlast, m_tuser[0],
				m_tdata[25], m_tdata[41:26]};
			if (expected_bytes.size() == 0) report("unexpected transaction", got, '0);
			else begin
				want = expected_bytes.pop_front();
				if (got !== want) report("result field", got, want);
			end
		end
	end

	// Called at a falling edge; s_tready only moves at rising edges.
	task automatic send(input logic [7:0] ch, input logic [63:0] arg, input logic eof);
		while ($urandom_range(99) < src_idle_pct) @(negedge clk);
		predict_format_char(ch, arg, eof);
		s_tvalid = 1'b1;
		s_tdata  = {arg, ch};
		s_tlast  = eof;
		while (!s_tready) @(negedge clk);
		@(posedge clk);
		// expectations join the queue at the accepting edge, ahead of any result
		foreach (staged[k]) expected_bytes.push_back(staged[k]);
		n_sent++;
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		while (expected_bytes.size() != 0 && guard < 200000) begin
			@(negedge clk);
			guard++;
		end
		repeat (200) @(negedge clk);
	endtask

	task automatic write_limit(input logic [15:0] lim);
		cfg_valid = 1'b1;
		cfg_data  = lim;
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		limit_q = lim;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Mostly well-formed strings: literals and conversions with random content.
	task automatic random_string(input int n_items);
		logic [7:0]  convs[6];
		logic [63:0] a;
		int          sel;
		convs = '{fsip_pkg::CH_C, fsip_pkg::CH_D, fsip_pkg::CH_I, fsip_pkg::CH_X,
			fsip_pkg::CH_O, fsip_pkg::CH_PCT};
		for (int k = 0; k < n_items; k++) begin
			sel = $urandom_range(99);
			a = {$urandom, $urandom};
			if ($urandom_range(3) == 0) a = $urandom_range(1) ? 64'h8000_0000_0000_0000 : 64'(a[3:0]);
			if (sel < 30) send(8'($urandom_range(255)), a, 1'b0);
			else if (sel < 95) begin
				send(fsip_pkg::CH_PCT, a, 1'b0);
				repeat ($urandom_range(3)) send(fsip_pkg::CH_SPACE, a, 1'b0);
				if ($urandom_range(9) == 0)
					repeat ($urandom_range(44)) send(fsip_pkg::CH_SPACE, a, 1'b0);
				repeat ($urandom_range(9) == 0 ? 3 : $urandom_range(2))
					send(fsip_pkg::CH_L, a, 1'b0);
				send(convs[$urandom_range(5)], a, 1'b0);
			end else send(fsip_pkg::CH_PCT, a, 1'b0);  // may leave a conversion open or hit a bad one
		end
		send(8'($urandom_range(255)), 64'h0, 1'b1);
	endtask

	row_t dir_rows[$];

	function automatic row_t mk(input logic [7:0] c, input logic [63:0] a, input logic e,
			input logic k, input byte_res_t w);
		row_t r;
		r.ch = c; r.arg = a; r.eof = e; r.chk = k; r.want = w;
		return r;
	endfunction

	initial begin
		int          base;
		logic [15:0] limits[5];
		errors = 0; n_sent = 0; src_idle_pct = 0; snk_stall_pct = 0;
		arst_n = 1'b0; s_tvalid = 1'b0; s_tdata = '0; s_tlast = 1'b0;
		m_tready = 1'b0; cfg_valid = 1'b0; cfg_data = '0;
		limit_q = 16'hffff; {in_spec_q, pad_q, longs_q, len_q, halt_q} = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Directed table: reset close, extremes of each conversion, error paths.
		dir_rows.push_back(mk(8'h00, 64'h0, 1'b1, 1'b1, {8'h00, 16'd0, 1'b1, 1'b1, 1'b1, 1'b0, 16'd0}));
		dir_rows.push_back(mk(8'h00, 64'h0, 1'b0, 1'b1, {8'h00, 16'd0, 1'b1, 1'b1, 1'b0, 1'b0, 16'd0}));
		dir_rows.push_back(mk(8'hff, 64'h0, 1'b0, 1'b0, '0));
		dir_rows.push_back(mk(fsip_pkg::CH_PCT, 64'h0, 1'b0, 1'b0, '0));
		dir_rows.push_back(mk(fsip_pkg::CH_SPACE, 64'h0, 1'b0, 1'b0, '0));
		dir_rows.push_back(mk(fsip_pkg::CH_D, 64'hffff_ffff_8000_0000, 1'b0, 1'b0, '0));
		dir_rows.push_back(mk(fsip_pkg::CH_PCT, 64'h0, 1'b0, 1'b0, '0));
		dir_rows.push_back(mk(fsip_pkg::CH_L, 64'h0, 1'b0, 1'b0, '0));
		dir_rows.push_back(mk(fsip_pkg::CH_I, 64'h8000_0000_0000_0000, 1'b0, 1'b0, '0));
		dir_rows.push_back(mk(fsip_pkg::CH_PCT, 64'h0, 1'b0, 1'b0, '0));
		dir_rows.push_back(mk(fsip_pkg::CH_L, 64'h0, 1'b0, 1'b0, '0));
		dir_rows.push_back(mk(fsip_pkg::CH_L, 64'h0, 1'b0, 1'b0, '0));
		dir_rows.push_back(mk(fsip_pkg::CH_X, 64'hffff_ffff_ffff_ffff, 1'b0, 1'b0, '0));
		dir_rows.push_back(mk(fsip_pkg::CH_PCT, 64'h0, 1'b0, 1'b0, '0));
		dir_rows.push_back(mk(fsip_pkg::CH_O, 64'hffff_ffff_ffff_ffff, 1'b0, 1'b0, '0));
		dir_rows.push_back(mk(fsip_pkg::CH_PCT, 64'h0, 1'b0, 1'b0, '0));
		dir_rows.push_back(mk(fsip_pkg::CH_SPACE, 64'h0, 1'b0, 1'b0, '0));
		dir_rows.push_back(mk(fsip_pkg::CH_C, 64'h41, 1'b0, 1'b0, '0));
		dir_rows.push_back(mk(fsip_pkg::CH_PCT, 64'h0, 1'b0, 1'b0, '0));
		dir_rows.push_back(mk(fsip_pkg::CH_PCT, 64'h0, 1'b0, 1'b0, '0));
		dir_rows.push_back(mk(fsip_pkg::CH_PCT, 64'h0, 1'b0, 1'b0, '0));
		dir_rows.push_back(mk(8'h73, 64'h0, 1'b0, 1'b0, '0));  // unknown specifier halts
		dir_rows.push_back(mk(8'h41, 64'h0, 1'b0, 1'b0, '0));
		dir_rows.push_back(mk(8'h00, 64'h0, 1'b1, 1'b0, '0));
		foreach (dir_rows[k]) begin
			if (dir_rows[k].chk) begin
				predict_format_char(dir_rows[k].ch, dir_rows[k].arg, dir_rows[k].eof);
				if (staged[0] !== dir_rows[k].want) report("directed row", staged[0], dir_rows[k].want);
				// roll back: send() predicts again from the same state
				if (dir_rows[k].eof) begin end else if (len_q != 0) len_q--;
			end
			send(dir_rows[k].ch, dir_rows[k].arg, dir_rows[k].eof);
			if (k == 3) repeat (41) send(fsip_pkg::CH_SPACE, 64'h0, 1'b0);  // pad saturation
		end
		// too many length modifiers, then a NUL specifier
		send(fsip_pkg::CH_PCT, 64'h0, 1'b0);
		repeat (4) send(fsip_pkg::CH_L, 64'h0, 1'b0);
		send(fsip_pkg::CH_D, 64'h0, 1'b0); send(8'h00, 64'h0, 1'b1);
		send(fsip_pkg::CH_PCT, 64'h0, 1'b0); send(8'h00, 64'h0, 1'b0); send(8'h00, 64'h0, 1'b1);
		send(fsip_pkg::CH_PCT, 64'h0, 1'b0); send(8'h00, 64'h0, 1'b1);  // open conversion at end
		drain();

		// Random phases over several buffer limits and idling patterns.
		limits = '{16'd0, 16'd1, 16'd5, 16'd37, 16'hffff};
		base = n_sent;
		for (int ph = 0; ph < 10; ph++) begin
			write_limit(limits[ph % 5]);
			case (ph % 4)
			0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
			1: begin src_idle_pct = 54; snk_stall_pct = 0;  end
			2: begin src_idle_pct = 0;  snk_stall_pct = 54; end
			default: begin src_idle_pct = 8; snk_stall_pct = 8; end
			endcase
			while (n_sent < base + (ph + 1) * 35)
				random_string($urandom_range(1, 6));
			drain();
		end
		src_idle_pct = 0; snk_stall_pct = 0;
		drain();

		if (errors == 0 && expected_bytes.size() == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end
endmodule

@@ files.f @@
hdl/fsip_pkg.sv
hdl/fsip_front.sv
hdl/fsip_queue.sv
hdl/fsip_back.sv
hdl/format_string_integer_printer.sv
sim/tb.sv
